>>> hdl/ille_pkg.sv
package ille_pkg;

    // Default list capacity, sentinel included
    localparam int SLOTS_DEF = 64;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int OUT_SLOT_W = 6;

    // Operation codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_FRESH,
        S_WALK,
        S_LINK_A,
        S_LINK_B,
        S_DONE
    } t_state;

endpackage

>>> hdl/ille_ram.sv
module ille_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/indexed_linked_list_engine_core.sv
// Doubly linked list engine over slot memories (value, next, previous), slot 0 being the
// sentinel and unused slots chained into a free list. One transaction at a time: a push
// passes through the check, the free-chain pop, the walk, the link writes and done; a pop
// skips the free-chain pop, and a rejected operation goes from the check straight to done.
// The walk follows one link per cycle through the registered read port of the next-link
// memory. After reset the block runs an initialization pass over all SLOTS slots that
// builds the free chain, with ready low. A finished result sits in an output register, so
// the next transaction can be taken while it waits.
module indexed_linked_list_engine_core #(
    parameter int SLOTS = ille_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic signed [31:0]             i_value,
    input  logic [ille_pkg::POS_W-1:0]     i_position,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ille_pkg::STATUS_W-1:0]  o_status,
    output logic signed [31:0]             o_removed_value,
    output logic [ille_pkg::OUT_SLOT_W-1:0] o_slot_used,
    output logic [ille_pkg::OUT_SLOT_W-1:0] o_item_count
);

    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > ille_pkg::POS_W) ? CW : ille_pkg::POS_W;
    localparam logic [SW:0] SLOTS_W = (SW + 1)'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    // Out-of-range link reads as the sentinel
    function automatic logic [SW-1:0] clamp_slot(input logic [SW-1:0] s);
        clamp_slot = ({1'b0, s} < SLOTS_W) ? s : '0;
    endfunction

    ille_pkg::t_state r_state, n_state;

    logic                          r_action, n_action;
    logic [31:0]                   r_value, n_value;
    logic [ille_pkg::POS_W-1:0]    r_cnt, n_cnt;
    logic [SW-1:0]                 r_at, n_at;
    logic [SW-1:0]                 r_fresh, n_fresh;
    logic [SW-1:0]                 r_after, n_after;
    logic [SW-1:0]                 r_before, n_before;
    logic [31:0]                   r_removed, n_removed;
    logic [SW-1:0]                 r_free_head, n_free_head;
    logic [CW-1:0]                 r_node_count, n_node_count;
    logic [ille_pkg::STATUS_W-1:0] r_status, n_status;
    logic [SW-1:0]                 r_slot, n_slot;

    logic                            r_out_valid, n_out_valid;
    logic [ille_pkg::STATUS_W-1:0]   r_o_status, n_o_status;
    logic [31:0]                     r_o_removed, n_o_removed;
    logic [ille_pkg::OUT_SLOT_W-1:0] r_o_slot, n_o_slot;
    logic [ille_pkg::OUT_SLOT_W-1:0] r_o_count, n_o_count;

    // Memory ports
    logic [SW-1:0] rd_addr;
    logic          nxt_we, prv_we, val_we;
    logic [SW-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, val_waddr;
    logic [SW-1:0] nxt_rd, prv_rd;
    logic [31:0]   val_rd;

    ille_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nxt_rd)
    );

    ille_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (prv_rd)
    );

    ille_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (val_rd)
    );

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ille_pkg::S_INIT;
            r_at         <= '0;
            r_free_head  <= SW'(1);
            r_node_count <= CW'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_at         <= n_at;
            r_free_head  <= n_free_head;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_value     <= n_value;
        r_cnt       <= n_cnt;
        r_fresh     <= n_fresh;
        r_after     <= n_after;
        r_before    <= n_before;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_slot    <= n_o_slot;
        r_o_count   <= n_o_count;
    end

    // Next state, memory control and result staging
    always_comb begin
        logic push_full;
        logic pos_over;

        n_state      = r_state;
        n_action     = r_action;
        n_value      = r_value;
        n_cnt        = r_cnt;
        n_at         = r_at;
        n_fresh      = r_fresh;
        n_after      = r_after;
        n_before     = r_before;
        n_removed    = r_removed;
        n_free_head  = r_free_head;
        n_node_count = r_node_count;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_removed  = r_o_removed;
        n_o_slot     = r_o_slot;
        n_o_count    = r_o_count;

        rd_addr   = '0;
        nxt_we    = 1'b0;
        nxt_waddr = '0;
        nxt_wdata = '0;
        prv_we    = 1'b0;
        prv_waddr = '0;
        prv_wdata = '0;
        val_we    = 1'b0;
        val_waddr = r_free_head;

        push_full = ((SW + 1)'(r_node_count) >= SLOTS_W) || (r_free_head == '0)
                    || ({1'b0, r_free_head} >= SLOTS_W);
        pos_over  = CMPW'(r_cnt) >= CMPW'(r_node_count);

        unique case (r_state)
            // Build the free chain: slot i links to i+1, sentinel and last to 0
            ille_pkg::S_INIT: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_at;
                nxt_wdata = ((r_at == '0) || (r_at == LAST_SLOT)) ? '0 : SW'(r_at + 1'b1);
                n_at      = SW'(r_at + 1'b1);
                if (r_at == LAST_SLOT) begin
                    n_at    = '0;
                    n_state = ille_pkg::S_IDLE;
                end
            end

            ille_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_value  = i_value;
                    n_cnt    = i_position;
                    n_at     = '0;
                    n_state  = ille_pkg::S_CHECK;
                end
            end

            // Range checks; a good push stores its value and fetches the free link
            ille_pkg::S_CHECK: begin
                n_removed = '0;
                n_slot    = '0;
                n_status  = ille_pkg::ST_OK;
                if (r_action == ille_pkg::ACT_PUSH) begin
                    rd_addr = r_free_head;
                    if (push_full) begin
                        n_status = ille_pkg::ST_NO_ROOM;
                        n_state  = ille_pkg::S_DONE;
                    end else if (pos_over) begin
                        n_status = ille_pkg::ST_BAD_POS;
                        n_state  = ille_pkg::S_DONE;
                    end else begin
                        val_we  = 1'b1;
                        n_fresh = r_free_head;
                        n_state = ille_pkg::S_FRESH;
                    end
                end else begin
                    rd_addr = '0;
                    if ((r_cnt == '0) || pos_over) begin
                        n_status = ille_pkg::ST_BAD_POS;
                        n_state  = ille_pkg::S_DONE;
                    end else begin
                        n_state = ille_pkg::S_WALK;
                    end
                end
            end

            // Pop the free chain, then start the walk at the sentinel
            ille_pkg::S_FRESH: begin
                n_free_head = clamp_slot(nxt_rd);
                rd_addr     = '0;
                n_state     = ille_pkg::S_WALK;
            end

            // One link per cycle; read data belongs to r_at
            ille_pkg::S_WALK: begin
                if (r_cnt == '0) begin
                    n_after  = clamp_slot(nxt_rd);
                    n_before = clamp_slot(prv_rd);
                    if (r_action == ille_pkg::ACT_POP) begin
                        n_removed = val_rd;
                    end
                    n_state = ille_pkg::S_LINK_A;
                end else begin
                    rd_addr = clamp_slot(nxt_rd);
                    n_at    = clamp_slot(nxt_rd);
                    n_cnt   = r_cnt - 1'b1;
                end
            end

            // First link pair
            ille_pkg::S_LINK_A: begin
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                prv_waddr = r_after;
                if (r_action == ille_pkg::ACT_PUSH) begin
                    nxt_waddr = r_fresh;
                    nxt_wdata = r_after;
                    prv_wdata = r_fresh;
                end else begin
                    nxt_waddr = r_before;
                    nxt_wdata = r_after;
                    prv_wdata = r_before;
                end
                n_state = ille_pkg::S_LINK_B;
            end

            // Second link pair and bookkeeping
            ille_pkg::S_LINK_B: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_at;
                if (r_action == ille_pkg::ACT_PUSH) begin
                    nxt_wdata    = r_fresh;
                    prv_we       = 1'b1;
                    prv_waddr    = r_fresh;
                    prv_wdata    = r_at;
                    n_node_count = r_node_count + 1'b1;
                    n_slot       = r_fresh;
                end else begin
                    nxt_wdata    = r_free_head;
                    n_free_head  = r_at;
                    n_node_count = r_node_count - 1'b1;
                    n_slot       = r_at;
                end
                n_state = ille_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free
            ille_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_removed = r_removed;
                    n_o_slot    = ille_pkg::OUT_SLOT_W'(r_slot);
                    n_o_count   = ille_pkg::OUT_SLOT_W'(r_node_count - 1'b1);
                    n_state     = ille_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ille_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready         = (r_state == ille_pkg::S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_slot_used     = r_o_slot;
    assign o_item_count    = r_o_count;

endmodule

>>> hdl/ille_checker.sv
module ille_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [ille_pkg::STATUS_W-1:0]   o_status,
    input logic signed [31:0]              o_removed_value,
    input logic [ille_pkg::OUT_SLOT_W-1:0] o_slot_used,
    input logic [ille_pkg::OUT_SLOT_W-1:0] o_item_count
);

    // Reset starts the initialization pass, so no request is taken next cycle
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("ready high right after reset");

    // One transaction at a time: accepting a request drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after accepting a request");

    // A rejected operation reports no slot and no value
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ille_pkg::ST_OK))
            |-> ((o_slot_used == '0) && (o_removed_value == '0)))
        else $error("error result carries a slot or value");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_slot_used) && $stable(o_item_count)))
        else $error("stalled result changed");

endmodule

bind indexed_linked_list_engine_core ille_checker u_ille_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_slot_used     (o_slot_used),
    .o_item_count    (o_item_count)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS_N     = ille_pkg::SLOTS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_OPS  = 500;
    localparam int SETTLE_CYC  = 80;
    localparam int RX_HOLD_CYC = 400;

    // One result transaction as the block reports it
    typedef struct packed {
        logic [ille_pkg::STATUS_W-1:0]   status;
        logic signed [31:0]              removed;
        logic [ille_pkg::OUT_SLOT_W-1:0] slot;
        logic [ille_pkg::OUT_SLOT_W-1:0] count;
    } t_list_result;

    // One row of the directed stimulus table
    typedef struct packed {
        logic                       act;
        logic signed [31:0]         val;
        logic [ille_pkg::POS_W-1:0] pos;
        logic                       typed;
        t_list_result               want;
    } t_op_row;

    typedef enum logic [1:0] {
        TREND_GROW,
        TREND_SHRINK,
        TREND_MIX
    } t_list_trend;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_action = ille_pkg::ACT_PUSH;
    logic signed [31:0]              i_value = '0;
    logic [ille_pkg::POS_W-1:0]      i_position = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [ille_pkg::STATUS_W-1:0]   o_status;
    logic signed [31:0]              o_removed_value;
    logic [ille_pkg::OUT_SLOT_W-1:0] o_slot_used;
    logic [ille_pkg::OUT_SLOT_W-1:0] o_item_count;

    indexed_linked_list_engine_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_slot_used    (o_slot_used),
        .o_item_count   (o_item_count)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the list storage
    logic [31:0]                list_vals [SLOTS_N];
    logic [ille_pkg::POS_W-1:0] list_next [SLOTS_N];
    logic [ille_pkg::POS_W-1:0] list_prev [SLOTS_N];
    logic [ille_pkg::POS_W-1:0] free_slot_head;
    logic [6:0]                 node_total;

    t_list_result pending_results[$];
    t_op_row      op_table[$];

    int err_count    = 0;
    int cycle_count  = 0;
    int results_seen = 0;
    int tx_idle_pct  = 17;
    int rx_idle_pct  = 51;
    int rx_hold_left = 0;
    bit rx_hold_done = 1'b0;

    // Follow next links from the sentinel
    function automatic logic [ille_pkg::POS_W-1:0] walk_from_sentinel(
            input logic [ille_pkg::POS_W-1:0] steps);
        logic [ille_pkg::POS_W-1:0] at;
        at = '0;
        for (int k = 0; k < steps; k++)
            at = list_next[at];
        return at;
    endfunction

    // Apply one list operation to the shadow storage and return its result
    function automatic t_list_result list_apply(input logic act, input logic [31:0] val,
                                                input logic [ille_pkg::POS_W-1:0] pos);
        t_list_result               r;
        logic [ille_pkg::POS_W-1:0] fresh;
        logic [ille_pkg::POS_W-1:0] at;
        logic [ille_pkg::POS_W-1:0] after;
        logic [ille_pkg::POS_W-1:0] prior;
        r.status  = ille_pkg::ST_OK;
        r.removed = '0;
        r.slot    = '0;
        if (act == ille_pkg::ACT_PUSH) begin
            if (node_total >= SLOTS_N || free_slot_head == '0) begin
                r.status = ille_pkg::ST_NO_ROOM;
            end else if (pos >= node_total) begin
                r.status = ille_pkg::ST_BAD_POS;
            end else begin
                fresh = free_slot_head;
                list_vals[fresh] = val;
                free_slot_head = list_next[fresh];
                at = walk_from_sentinel(pos);
                after = list_next[at];
                list_next[fresh] = after;
                list_prev[after] = fresh;
                list_next[at] = fresh;
                list_prev[fresh] = at;
                node_total++;
                r.slot = fresh;
            end
        end else begin
            if (pos == '0 || pos >= node_total) begin
                r.status = ille_pkg::ST_BAD_POS;
            end else begin
                at = walk_from_sentinel(pos);
                after = list_next[at];
                prior = list_prev[at];
                r.removed = list_vals[at];
                list_next[prior] = after;
                list_prev[after] = prior;
                list_next[at] = free_slot_head;
                free_slot_head = at;
                node_total--;
                r.slot = at;
            end
        end
        r.count = ille_pkg::OUT_SLOT_W'(node_total - 7'd1);
        return r;
    endfunction

    function automatic t_op_row mk_row(input logic act, input logic [31:0] val,
                                       input logic [ille_pkg::POS_W-1:0] pos,
                                       input logic typed,
                                       input logic [ille_pkg::STATUS_W-1:0] st,
                                       input logic [ille_pkg::OUT_SLOT_W-1:0] slot,
                                       input logic [ille_pkg::OUT_SLOT_W-1:0] cnt);
        t_op_row row;
        row.act          = act;
        row.val          = val;
        row.pos          = pos;
        row.typed        = typed;
        row.want.status  = st;
        row.want.removed = '0;
        row.want.slot    = slot;
        row.want.count   = cnt;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch @%0d: %s got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // Offer one transaction, wait for acceptance, then record its expected result
    task automatic send_op(input logic act, input logic [31:0] val,
                           input logic [ille_pkg::POS_W-1:0] pos,
                           input logic typed, input t_list_result want,
                           output logic [ille_pkg::STATUS_W-1:0] st);
        int           gap;
        t_list_result r;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_ready !== 1'b1)
            @(posedge i_clk);
        r = list_apply(act, val, pos);
        pending_results.push_back(typed ? want : r);
        st = r.status;
    endtask

    // Stop offering until every outstanding result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (!rx_hold_done && results_seen >= 60) begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_CYC;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_status), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_removed_value !== want.removed)
                    report_mismatch("removed_value", o_removed_value, want.removed);
                if (o_slot_used !== want.slot)
                    report_mismatch("slot_used", 32'(o_slot_used), 32'(want.slot));
                if (o_item_count !== want.count)
                    report_mismatch("item_count", 32'(o_item_count), 32'(want.count));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [ille_pkg::STATUS_W-1:0] st;
        logic                          act;
        logic [31:0]                   val;
        logic [ille_pkg::POS_W-1:0]    pos;
        t_list_trend                   trend;
        int                            push_pct;
        int                            mix_left;
        t_op_row                       row;

        // Shadow storage at reset
        for (int i = 0; i < SLOTS_N; i++) begin
            list_vals[i] = '0;
            list_prev[i] = '0;
            list_next[i] = ille_pkg::POS_W'(i + 1);
        end
        list_next[0]         = '0;
        list_next[SLOTS_N-1] = '0;
        free_slot_head       = ille_pkg::POS_W'(1);
        node_total           = 7'd1;

        // Directed table: errors on an empty list, extremes, then short push/pop mix
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd0,  1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd1,  1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'hFFFFFFFF, 6'd63, 1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'hFFFFFFFF, 6'd1,  1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h0,        6'd63, 1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h80000000, 6'd0,  1'b1,
                                  ille_pkg::ST_OK,      6'd1, 6'd1));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h7FFFFFFF, 6'd1,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'hFFFFFFFF, 6'd0,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd0,  1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd3));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd63, 1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd3));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h0,        6'd4,  1'b1,
                                  ille_pkg::ST_BAD_POS, 6'd0, 6'd3));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h12345678, 6'd3,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h55555555, 6'd2,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'hAAAAAAAA, 6'd3,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd1,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd2,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd1,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd1,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_POP,  32'h0,        6'd1,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));
        op_table.push_back(mk_row(ille_pkg::ACT_PUSH, 32'h00000001, 6'd0,  1'b0,
                                  ille_pkg::ST_OK,      6'd0, 6'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (op_table[i]) begin
            row = op_table[i];
            send_op(row.act, row.val, row.pos, row.typed, row.want, st);
        end
        wait_results_drained();

        // Random part: fill to full, drain to empty, wander, repeat
        trend    = TREND_GROW;
        mix_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 3) begin
                wait_results_drained();
                tx_idle_pct = 51;
                rx_idle_pct = 17;
            end
            if (n == 2 * RANDOM_OPS / 3) begin
                wait_results_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 10) begin
                // noise: any action at any position
                act = 1'($urandom_range(0, 1));
                pos = ille_pkg::POS_W'($urandom_range(0, 63));
            end else begin
                case (trend)
                    TREND_GROW:   push_pct = 90;
                    TREND_SHRINK: push_pct = 10;
                    default:      push_pct = 50;
                endcase
                act = ($urandom_range(0, 99) < push_pct) ? ille_pkg::ACT_PUSH
                                                         : ille_pkg::ACT_POP;
                if (act == ille_pkg::ACT_POP && node_total <= 1)
                    act = ille_pkg::ACT_PUSH;
                if (act == ille_pkg::ACT_PUSH && node_total >= SLOTS_N
                        && trend != TREND_GROW)
                    act = ille_pkg::ACT_POP;
                if (act == ille_pkg::ACT_PUSH)
                    pos = ille_pkg::POS_W'($urandom_range(0, int'(node_total) - 1));
                else
                    pos = ille_pkg::POS_W'($urandom_range(1, int'(node_total) - 1));
            end
            val = $urandom();
            send_op(act, val, pos, 1'b0, '0, st);

            case (trend)
                TREND_GROW: begin
                    if (st == ille_pkg::ST_NO_ROOM)
                        trend = TREND_SHRINK;
                end
                TREND_SHRINK: begin
                    if (node_total == 1) begin
                        trend    = TREND_MIX;
                        mix_left = 40;
                    end
                end
                default: begin
                    mix_left--;
                    if (mix_left <= 0)
                        trend = TREND_GROW;
                end
            endcase
        end

        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/ille_pkg.sv
hdl/ille_ram.sv
hdl/indexed_linked_list_engine_core.sv
hdl/ille_checker.sv
sim/testbench.sv
